// ----- src/mmh_pkg.sv -----
`default_nettype none
package mmh_pkg;

  // Mixing constant and shift of the hash
  localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] M_LO  = MIX_M[31:0];
  localparam logic [31:0] M_HI  = MIX_M[63:32];
  localparam int unsigned MIX_R = 47;

  // Defaults for the top-level parameters
  localparam int unsigned LENGTH_BITS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Width of the key length carried through the queue (covers any LENGTH_BITS)
  localparam int unsigned KLEN_W = 32;

  // What the back end does with one chunk
  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,
    KIND_PART = 2'd1,
    KIND_NONE = 2'd2
  } chunk_kind_t;

  // One classified chunk, as queued between front and back
  typedef struct packed {
    logic              start;
    logic [KLEN_W-1:0] klen;
    chunk_kind_t       kind;
    logic [2:0]        nbytes;
    logic [63:0]       data;
    logic              last;
    logic              mismatch;
  } mmh_op_t;

  // x ^ (x >> 47)
  function automatic logic [63:0] fold47(input logic [63:0] x);
    fold47 = x ^ (x >> MIX_R);
  endfunction

  // Mask keeping the low n bytes of a word
  function automatic logic [63:0] byte_mask(input logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < n) ? 8'hff : 8'h00;
    end
    byte_mask = m;
  endfunction

endpackage
`default_nettype wire

// ----- src/murmur64a_key_hasher.sv -----
`default_nettype none
// Streaming MurmurHash64A of keys sent as 8-byte little-endian chunks; the first
// chunk carries the key length, the last one makes the block emit the finalised
// hash and a flag telling whether the chunks used up the declared length
// exactly. Every step multiplies by the mixing constant on one shared 32x32
// multiplier that builds each 64-bit product from the partial products lo*lo,
// hi*lo and lo*hi. A full-word chunk takes the k, k-mix and h multiplies, a
// partial chunk only the h multiply, a chunk past the declared length none;
// the first chunk of a key adds the seed multiply and the last adds the
// finaliser. A short queue lets chunks be accepted while the back end works,
// and the result register lets hashing continue while a result waits. The user
// must write the seed register through the configuration channel only while no
// key is in flight; the block itself does not enforce this. It is always ready.
module murmur64a_key_hasher #(
  parameter int unsigned LENGTH_BITS = mmh_pkg::LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = mmh_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        start_of_key,
  input  wire logic [15:0] key_length,
  input  wire logic [63:0] chunk,
  input  wire logic        end_of_key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      hash_value,
  output logic             length_mismatch
);
  import mmh_pkg::*;

  localparam int unsigned PEND_W = $clog2(QUEUE_DEPTH + 3);

  logic [31:0]  seed;
  logic         push_valid;
  logic         push_ready;
  mmh_op_t      push_data;
  logic         pop_valid;
  logic         pop_ready;
  mmh_op_t      pop_data;
  logic [PEND_W-1:0] pending;
  logic         in_last;
  logic         out_fire;

  assign cfg_ready = 1'b1;

  // Hold the seed register
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed <= cfg_data;
    end
  end

  mmh_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .start_of_key (start_of_key),
    .key_length   (key_length),
    .chunk        (chunk),
    .end_of_key   (end_of_key),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  mmh_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  mmh_back u_back (
    .clk             (clk),
    .rst             (rst),
    .seed            (seed),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hash_value      (hash_value),
    .length_mismatch (length_mismatch)
  );

  // Count final chunks taken in but not yet delivered
  assign in_last  = in_valid && in_ready && end_of_key;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_last && !out_fire) begin
      pending <= pending + PEND_W'(1);
    end else if (out_fire && !in_last) begin
      pending <= pending - PEND_W'(1);
    end
  end

  // A result only ever stands for a final chunk already taken in
  a_out_has_key: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("result without a pending final chunk");

  // A final chunk leaves a key pending in the next cycle
  a_last_pending: assert property (@(posedge clk) disable iff (rst)
    in_last |=> (pending != '0))
    else $error("final chunk not tracked");

  // Keys in flight are bounded by the queue, the back end and the result slot
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(QUEUE_DEPTH + 2))
    else $error("more keys in flight than storage allows");

endmodule
`default_nettype wire

// ----- src/mmh_front.sv -----
`default_nettype none
module mmh_front #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           start_of_key,
  input  wire logic [15:0]    key_length,
  input  wire logic [63:0]    chunk,
  input  wire logic           end_of_key,
  output logic                push_valid,
  input  wire logic           push_ready,
  output mmh_pkg::mmh_op_t    push_data
);
  import mmh_pkg::*;

  logic [LENGTH_BITS-1:0] rem;
  logic [LENGTH_BITS-1:0] rem_next;
  logic                   flag;
  logic                   flag_next;

  logic [47:0]            klen_wide;
  logic [LENGTH_BITS-1:0] klen;
  logic [LENGTH_BITS-1:0] rem_cur;
  logic                   flag_cur;
  logic                   empty_start;
  logic                   is_full;
  logic                   is_part;
  logic                   excess;

  // Classify the incoming chunk against the bytes still declared
  always_comb begin
    klen_wide   = {32'b0, key_length};
    klen        = klen_wide[LENGTH_BITS-1:0];
    rem_cur     = start_of_key ? klen : rem;
    flag_cur    = start_of_key ? 1'b0 : flag;
    empty_start = start_of_key && (klen == '0);
    is_full     = |rem_cur[LENGTH_BITS-1:3];
    is_part     = !is_full && (rem_cur != '0);
    excess      = !is_full && !is_part && !empty_start;
    rem_next    = is_full ? (rem_cur - LENGTH_BITS'(8)) : '0;
    flag_next   = flag_cur || excess || (end_of_key && (rem_next != '0));
  end

  // Build the queue entry
  always_comb begin
    push_data.start    = start_of_key;
    push_data.klen     = KLEN_W'(klen);
    push_data.kind     = is_full ? KIND_FULL : (is_part ? KIND_PART : KIND_NONE);
    push_data.nbytes   = rem_cur[2:0];
    push_data.data     = chunk;
    push_data.last     = end_of_key;
    push_data.mismatch = flag_next;
  end

  assign push_valid = in_valid;
  assign in_ready   = push_ready;

  // Advance the length bookkeeping on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      rem  <= '0;
      flag <= 1'b0;
    end else if (in_valid && push_ready) begin
      rem  <= rem_next;
      flag <= flag_next;
    end
  end

endmodule
`default_nettype wire

// ----- src/mmh_queue.sv -----
`default_nettype none
module mmh_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire mmh_pkg::mmh_op_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output mmh_pkg::mmh_op_t      pop_data
);
  import mmh_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mmh_op_t         slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Hold entries; payload needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/mmh_mul.sv -----
`default_nettype none
module mmh_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] operand,
  output logic             done,
  output logic [63:0]      product
);
  import mmh_pkg::*;

  logic [63:0] a;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;

  // Pick the partial product for this step: lo*lo, hi*lo, lo*hi
  always_comb begin
    case (step)
      2'd0:    begin mul_x = a[31:0];  mul_y = M_LO; end
      2'd1:    begin mul_x = a[63:32]; mul_y = M_LO; end
      default: begin mul_x = a[31:0];  mul_y = M_HI; end
    endcase
    prod = 64'(mul_x) * 64'(mul_y);
  end

  assign product = acc;

  // Accumulate the low 64 bits of operand * M, one partial product per step
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= busy && (step == 2'd2);
      if (start && !busy) begin
        a    <= operand;
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        if (step == 2'd0) begin
          acc <= prod;
        end else begin
          acc[63:32] <= acc[63:32] + prod[31:0];
        end
        if (step == 2'd2) begin
          busy <= 1'b0;
          step <= 2'd0;
        end else begin
          step <= step + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/mmh_back.sv -----
`default_nettype none
module mmh_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      seed,
  input  wire logic             pop_valid,
  output logic                  pop_ready,
  input  wire mmh_pkg::mmh_op_t pop_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [63:0]           hash_value,
  output logic                  length_mismatch
);
  import mmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEED,
    S_DISPATCH,
    S_K1,
    S_K2,
    S_H,
    S_FIN,
    S_EMIT
  } state_t;

  state_t      state;
  mmh_op_t     cur;
  logic [63:0] h;
  logic        mul_start;
  logic [63:0] mul_op;
  logic        mul_done;
  logic [63:0] mul_prod;

  mmh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .operand (mul_op),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign pop_ready = (state == S_IDLE);

  // Sequence the hash steps of one chunk over the shared multiplier
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
      h         <= '0;
    end else begin
      // Drop the result once taken, unless a new one replaces it
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          mul_start <= pop_valid && pop_data.start;
          if (pop_valid) begin
            cur <= pop_data;
            if (pop_data.start) begin
              mul_op    <= 64'(pop_data.klen);
              state     <= S_SEED;
            end else begin
              state <= S_DISPATCH;
            end
          end
        end
        S_SEED: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            h     <= 64'(seed) ^ mul_prod;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          mul_start <= (cur.kind == KIND_FULL) || (cur.kind == KIND_PART) || cur.last;
          unique case (cur.kind)
            KIND_FULL: begin
              mul_op    <= cur.data;
              state     <= S_K1;
            end
            KIND_PART: begin
              mul_op    <= h ^ (cur.data & byte_mask(cur.nbytes));
              state     <= S_H;
            end
            default: begin
              if (cur.last) begin
                mul_op    <= fold47(h);
                state     <= S_FIN;
              end else begin
                state <= S_IDLE;
              end
            end
          endcase
        end
        S_K1: begin
          mul_start <= mul_done;
          if (mul_done) begin
            mul_op    <= fold47(mul_prod);
            state     <= S_K2;
          end
        end
        S_K2: begin
          mul_start <= mul_done;
          if (mul_done) begin
            mul_op    <= h ^ mul_prod;
            state     <= S_H;
          end
        end
        S_H: begin
          mul_start <= mul_done && cur.last;
          if (mul_done) begin
            h <= mul_prod;
            if (cur.last) begin
              mul_op    <= fold47(mul_prod);
              state     <= S_FIN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_FIN: begin
          mul_start <= 1'b0;
          if (mul_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          mul_start <= 1'b0;
          // Product stays in the multiplier until the next start
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            hash_value      <= fold47(mul_prod);
            length_mismatch <= cur.mismatch;
            state           <= S_IDLE;
          end
        end
        default: begin
          mul_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
